/* rtl/core/sdbt_pkg.sv */
// sdbt_pkg: shared types, constants and helpers of the sparse disk block translator
// no dependencies; compiled first
package sdbt_pkg;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_MAX_REQUEST = 16384;

    localparam int INDEX_W   = 12;
    localparam int WORD_W    = 32;
    localparam int OFFSET_W  = 48;
    localparam int LEN_W     = 15;
    localparam int LG_W      = 5;
    localparam int ENTRIES_W = 13;
    localparam int BN_W      = 39;
    localparam int SECTOR_SHIFT = 9;
    localparam int MIN_LG       = 9;
    localparam int BITMAP_SHIFT = 12;
    localparam logic [WORD_W-1:0] UNALLOC = 32'hFFFF_FFFF;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_BLOCK_SIZE_LOG2 = 2'd0;
    localparam t_reg_idx REG_TABLE_ENTRIES   = 2'd1;
    localparam t_reg_idx REG_VOLUME_SIZE     = 2'd2;
    localparam t_reg_idx REG_IMAGE_SIZE      = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ZERO    = 2'd0;
    localparam t_kind KIND_COPY    = 2'd1;
    localparam t_kind KIND_IDX_ERR = 2'd2;
    localparam t_kind KIND_OUT_ERR = 2'd3;

    typedef struct packed {
        logic [LG_W-1:0]      lg;
        logic [ENTRIES_W-1:0] entries;
        logic [OFFSET_W-1:0]  volume;
        logic [OFFSET_W-1:0]  image;
    } t_cfg;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic clamp;
        logic block;
        logic mem;
        logic check;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic rem_zero;
        logic bn_oor;
        logic last;
    } t_sts;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* rtl/core/sdbt_if.sv */
// sdbt_req_if and sdbt_chunk_if: valid/ready channels for requests and chunks
// depends on sdbt_pkg for field widths
interface sdbt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [sdbt_pkg::INDEX_W-1:0]   table_index;
    logic [sdbt_pkg::WORD_W-1:0]    table_word;
    logic [sdbt_pkg::OFFSET_W-1:0]  read_offset;
    logic [sdbt_pkg::LEN_W-1:0]     read_length;

    modport source (output valid, func, table_index, table_word, read_offset, read_length,
                    input ready);
    modport sink (input valid, func, table_index, table_word, read_offset, read_length,
                  output ready);
endinterface

interface sdbt_chunk_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     chunk_kind;
    logic [sdbt_pkg::OFFSET_W-1:0]  image_offset;
    logic                           need_fetch;
    logic [sdbt_pkg::OFFSET_W-1:0]  fetch_offset;
    logic [sdbt_pkg::LEN_W-1:0]     chunk_length;
    logic [sdbt_pkg::LEN_W-1:0]     dest_offset;
    logic                           last;

    modport source (output valid, chunk_kind, image_offset, need_fetch, fetch_offset,
                    chunk_length, dest_offset, last, input ready);
    modport sink (input valid, chunk_kind, image_offset, need_fetch, fetch_offset,
                  chunk_length, dest_offset, last, output ready);
endinterface

/* rtl/core/sdbt_regs.sv */
// sdbt_regs: apb configuration registers of the translator
// depends on sdbt_pkg
module sdbt_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdbt_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdbt_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdbt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output sdbt_pkg::t_cfg                o_cfg
);
    import sdbt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = paddr[PADDR_W-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lg      <= LG_W'(21);
            r_cfg.entries <= ENTRIES_W'(4096);
            r_cfg.volume  <= '0;
            r_cfg.image   <= '0;
        end else if (wr) begin
            case (idx)
                REG_BLOCK_SIZE_LOG2: r_cfg.lg      <= pwdata[LG_W-1:0];
                REG_TABLE_ENTRIES:   r_cfg.entries <= pwdata[ENTRIES_W-1:0];
                REG_VOLUME_SIZE:     r_cfg.volume  <= pwdata[OFFSET_W-1:0];
                REG_IMAGE_SIZE:      r_cfg.image   <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BLOCK_SIZE_LOG2: prdata = PDATA_W'(r_cfg.lg);
            REG_TABLE_ENTRIES:   prdata = PDATA_W'(r_cfg.entries);
            REG_VOLUME_SIZE:     prdata = PDATA_W'(r_cfg.volume);
            REG_IMAGE_SIZE:      prdata = PDATA_W'(r_cfg.image);
            default:             prdata = '0;
        endcase
    end

endmodule

/* rtl/core/sdbt_ctrl.sv */
// sdbt_ctrl: sequencer of the translator, drives handshakes and datapath commands
// depends on sdbt_pkg
module sdbt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  sdbt_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output sdbt_pkg::t_cmd  o_cmd
);
    import sdbt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLAMP = 6'b000010,
        S_BLOCK = 6'b000100,
        S_MEM   = 6'b001000,
        S_CHECK = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.func) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_CLAMP;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_BLOCK;
            end
            S_BLOCK: begin
                o_cmd.block = 1'b1;
                if (i_sts.rem_zero || i_sts.bn_oor) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                o_cmd.mem = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_BLOCK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while a chunk is pending");

    a_next_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !i_sts.last) |=> (r_state == S_BLOCK))
        else $error("run did not continue after a non-final chunk");

    a_early_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLOCK && (i_sts.rem_zero || i_sts.bn_oor)) |=> o_out_valid)
        else $error("empty or index-error chunk not presented");

endmodule

/* rtl/core/sdbt_dp.sv */
// sdbt_dp: translator datapath with allocation table memory, cache tag and chunk register
// depends on sdbt_pkg
module sdbt_dp #(
    parameter int TABLE_DEPTH = sdbt_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_REQUEST = sdbt_pkg::DEF_MAX_REQUEST
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sdbt_pkg::t_cfg                 i_cfg,
    input  sdbt_pkg::t_cmd                 i_cmd,
    input  logic                           i_func,
    input  logic [sdbt_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [sdbt_pkg::WORD_W-1:0]    i_table_word,
    input  logic [sdbt_pkg::OFFSET_W-1:0]  i_read_offset,
    input  logic [sdbt_pkg::LEN_W-1:0]     i_read_length,
    output sdbt_pkg::t_sts                 o_sts,
    output logic [1:0]                     o_chunk_kind,
    output logic [sdbt_pkg::OFFSET_W-1:0]  o_image_offset,
    output logic                           o_need_fetch,
    output logic [sdbt_pkg::OFFSET_W-1:0]  o_fetch_offset,
    output logic [sdbt_pkg::LEN_W-1:0]     o_chunk_length,
    output logic [sdbt_pkg::LEN_W-1:0]     o_dest_offset,
    output logic                           o_last
);
    import sdbt_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW  = $clog2(MAX_REQUEST + 1);
    localparam int EW0 = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = (EW0 > ENTRIES_W) ? EW0 : ENTRIES_W;
    localparam int SW  = ((LW > LEN_W) ? LW : LEN_W) + 1;
    localparam int BW  = WORD_W + SECTOR_SHIFT;

    logic [WORD_W-1:0]   mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   r_word;

    logic [OFFSET_W-1:0] r_off;
    logic [LEN_W-1:0]    r_len;
    logic [LW-1:0]       r_rem;
    logic [LW-1:0]       r_dest;
    logic [BN_W-1:0]     r_bn;
    logic [WORD_W-1:0]   r_inblk;
    logic [LW-1:0]       r_tx;
    logic                r_last;

    logic [BW-1:0]       r_base;
    logic [OFFSET_W-1:0] r_img;
    logic [OFFSET_W-1:0] r_lim;
    logic                r_miss;
    logic                r_unalloc;

    logic                r_cache_valid;
    logic [BN_W-1:0]     r_cached;

    t_kind               r_o_kind;
    logic [OFFSET_W-1:0] r_o_img;
    logic                r_o_fetch;
    logic [OFFSET_W-1:0] r_o_foff;
    logic [LW-1:0]       r_o_len;
    logic [LW-1:0]       r_o_dest;
    logic                r_o_last;

    logic [LG_W-1:0]     lg_eff;
    logic [WORD_W-1:0]   bsize;
    logic [WORD_W-1:0]   bitmap;
    logic [EW-1:0]       entries_eff;
    logic                idx_ok;
    logic [LW-1:0]       sat_c;
    logic [OFFSET_W:0]   gap_c;
    logic [LW-1:0]       rem_c;
    logic [OFFSET_W-1:0] shifted;
    logic [BN_W-1:0]     bn_c;
    logic [WORD_W-1:0]   inblk_c;
    logic [WORD_W-1:0]   room_c;
    logic                fits_c;
    logic [LW-1:0]       tx_c;
    logic                bn_oor;
    logic [WORD_W-1:0]   sector_c;
    logic [BW-1:0]       base_c;
    logic                out_fail;

    assign lg_eff      = (i_cfg.lg < LG_W'(MIN_LG)) ? LG_W'(MIN_LG) : i_cfg.lg;
    assign bsize       = 32'd1 << lg_eff;
    assign bitmap      = bsize >> BITMAP_SHIFT;
    assign entries_eff = (EW'(i_cfg.entries) < EW'(TABLE_DEPTH)) ? EW'(i_cfg.entries)
                                                                 : EW'(TABLE_DEPTH);
    assign idx_ok      = EW'(i_table_index) < EW'(TABLE_DEPTH);

    // length clamp to request limit and volume end
    assign sat_c = (SW'(r_len) > SW'(MAX_REQUEST)) ? LW'(MAX_REQUEST) : LW'(r_len);
    assign gap_c = {1'b0, i_cfg.volume} - {1'b0, r_off};
    assign rem_c = gap_c[OFFSET_W] ? '0 :
                   (gap_c[OFFSET_W-1:0] < OFFSET_W'(sat_c)) ? gap_c[LW-1:0] : sat_c;

    // block split
    assign shifted = r_off >> lg_eff;
    assign bn_c    = shifted[BN_W-1:0];
    assign inblk_c = r_off[WORD_W-1:0] & (bsize - 32'd1);
    assign room_c  = bsize - inblk_c;
    assign fits_c  = WORD_W'(r_rem) <= room_c;
    assign tx_c    = fits_c ? r_rem : room_c[LW-1:0];
    assign bn_oor  = bn_c >= BN_W'(entries_eff);

    assign sector_c = swap32(r_word);
    assign base_c   = {sector_c, {SECTOR_SHIFT{1'b0}}};
    assign out_fail = r_miss && (r_lim > i_cfg.image);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && idx_ok) begin
            mem[AW'(i_table_index)] <= i_table_word;
        end
        if (i_cmd.block) begin
            r_word <= mem[AW'(bn_c)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_valid <= 1'b0;
        end else if (i_cmd.check && !r_unalloc && r_miss && !out_fail) begin
            r_cache_valid <= 1'b1;
            r_cached      <= r_bn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_off  <= i_read_offset;
            r_len  <= i_read_length;
            r_dest <= '0;
        end
        if (i_cmd.clamp) begin
            r_rem <= rem_c;
        end
        if (i_cmd.block) begin
            r_bn    <= bn_c;
            r_inblk <= inblk_c;
            r_tx    <= tx_c;
            r_last  <= fits_c;
            if (r_rem == '0) begin
                r_o_kind  <= KIND_ZERO;
                r_o_img   <= '0;
                r_o_fetch <= 1'b0;
                r_o_foff  <= '0;
                r_o_len   <= '0;
                r_o_dest  <= '0;
                r_o_last  <= 1'b1;
            end else if (bn_oor) begin
                r_o_kind  <= KIND_IDX_ERR;
                r_o_img   <= '0;
                r_o_fetch <= 1'b0;
                r_o_foff  <= '0;
                r_o_len   <= '0;
                r_o_dest  <= r_dest;
                r_o_last  <= 1'b1;
            end
        end
        if (i_cmd.mem) begin
            r_base    <= base_c;
            r_img     <= OFFSET_W'(base_c) + OFFSET_W'(bitmap) + OFFSET_W'(r_inblk);
            r_lim     <= OFFSET_W'(base_c) + OFFSET_W'(bitmap) + OFFSET_W'(bsize);
            r_miss    <= !r_cache_valid || (r_cached != r_bn);
            r_unalloc <= (sector_c == UNALLOC);
        end
        if (i_cmd.check) begin
            r_o_dest <= r_dest;
            if (r_unalloc) begin
                r_o_kind  <= KIND_ZERO;
                r_o_img   <= '0;
                r_o_fetch <= 1'b0;
                r_o_foff  <= '0;
                r_o_len   <= r_tx;
                r_o_last  <= r_last;
            end else if (out_fail) begin
                r_o_kind  <= KIND_OUT_ERR;
                r_o_img   <= '0;
                r_o_fetch <= 1'b0;
                r_o_foff  <= '0;
                r_o_len   <= '0;
                r_o_last  <= 1'b1;
            end else begin
                r_o_kind  <= KIND_COPY;
                r_o_img   <= r_img;
                r_o_fetch <= r_miss;
                r_o_foff  <= r_miss ? OFFSET_W'(r_base) : '0;
                r_o_len   <= r_tx;
                r_o_last  <= r_last;
            end
        end
        if (i_cmd.advance) begin
            r_off  <= r_off + OFFSET_W'(r_tx);
            r_dest <= r_dest + r_tx;
            r_rem  <= r_rem - r_tx;
        end
    end

    assign o_sts.func     = i_func;
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.bn_oor   = bn_oor;
    assign o_sts.last     = r_o_last;

    assign o_chunk_kind   = r_o_kind;
    assign o_image_offset = r_o_img;
    assign o_need_fetch   = r_o_fetch;
    assign o_fetch_offset = r_o_foff;
    assign o_chunk_length = LEN_W'(r_o_len);
    assign o_dest_offset  = LEN_W'(r_o_dest);
    assign o_last         = r_o_last;

    a_adv_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_tx < r_rem))
        else $error("advance past the end of the request");

    a_cache_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.check && !r_unalloc && r_miss && !out_fail)
        |=> (r_cache_valid && r_cached == $past(r_bn)))
        else $error("cache tag not updated on fetch");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.block |-> (SW'(r_rem) <= SW'(MAX_REQUEST)))
        else $error("remaining length above request limit");

endmodule

/* rtl/core/sparse_disk_block_translator_core.sv */
// sparse_disk_block_translator_core: top level of the sparse disk block translator
// depends on sdbt_pkg, sdbt_if, sdbt_regs, sdbt_ctrl, sdbt_dp
//
//  channel   dir  handshake              payload
//  i_req     in   valid/ready            func, table_index, table_word, read_offset, read_length
//  o_chunk   out  valid/ready            kind, offsets, fetch flag, length, dest, last
//  apb       in   psel/penable, pready   paddr, pwdata, prdata (64 bit, regs at 8*i)
//
// a table load is written while idle; a read clamps its length once, then steps each chunk
// through block split, table memory read, registered offset adds and check to output;
// an empty or index-error chunk goes from block split straight to output
// one request in flight; i_req.ready is low until its last chunk beat is taken
// o_chunk stalls hold the chunk register and the sequencer
// synchronous active-low reset; table memory is not cleared, cache is invalidated
module sparse_disk_block_translator_core #(
    parameter int TABLE_DEPTH = sdbt_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_REQUEST = sdbt_pkg::DEF_MAX_REQUEST
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sdbt_req_if.sink                      i_req,
    sdbt_chunk_if.source                  o_chunk,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdbt_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdbt_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdbt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sdbt_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    sdbt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sdbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_chunk.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    sdbt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_func         (i_req.func),
        .i_table_index  (i_req.table_index),
        .i_table_word   (i_req.table_word),
        .i_read_offset  (i_req.read_offset),
        .i_read_length  (i_req.read_length),
        .o_sts          (sts),
        .o_chunk_kind   (o_chunk.chunk_kind),
        .o_image_offset (o_chunk.image_offset),
        .o_need_fetch   (o_chunk.need_fetch),
        .o_fetch_offset (o_chunk.fetch_offset),
        .o_chunk_length (o_chunk.chunk_length),
        .o_dest_offset  (o_chunk.dest_offset),
        .o_last         (o_chunk.last)
    );

    assign i_req.ready   = in_ready;
    assign o_chunk.valid = out_valid;

endmodule
